// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed");

// Next-cycle check that is also active while reset is asserted.
`define CHK_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hdl/opi_pkg.sv =====
// Types, arithmetic constants and the arctangent table of the odometry integrator.
package opi_pkg;

    localparam logic [20:0] DEN_DR   = 21'd1000000;
    localparam logic [20:0] HALF_DR  = 21'd500000;
    localparam logic [20:0] DEN_ANG  = 21'd703125;
    localparam logic [20:0] HALF_ANG = 21'd351562;
    localparam logic [23:0] INV_GAIN = 24'd10188014;
    localparam int          GAIN_STEPS = 24;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef enum logic [1:0] {
        PH_DR   = 2'd0,
        PH_DTH  = 2'd1,
        PH_HALF = 2'd2
    } t_phase;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_LD   = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_GAIN = 8'b0001_0000,
        S_ROT  = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

// ===== hdl/odometry_pose_integrator_core.sv =====
// Dead-reckoning pose integrator with a serial divider, serial gain multiply and CORDIC.
//
//   Channel   Dir   Beat content (lowest bits first)
//   s stream  in    tuser: subscribed, new_command; tdata: speed_cmd, turn_cmd, step_us
//   m stream  out   x_mm, y_mm, heading_deg, speed_echo, turn_echo
//
// A subscribed tick runs S_MUL, then S_LD and S_DIV in each of three phases, S_GAIN,
// S_ROT and S_ACC; then S_DONE loads the result register. The bit-serial divider is NW
// bits wide, NW being max(POS_FRAC_BITS, 23) + 33. An unsubscribed tick goes straight
// to S_DONE. The input is ready again once the result is loaded. Reset clears the pose and commands.
// A result waiting on the output register does not block the next input beat; the
// next tick then waits in its last state until the result register is free.
module odometry_pose_integrator_core #(
    parameter int CORDIC_STEPS  = 24,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // subscribed, new_command
    input  logic [1:0]   i_s_tuser,
    // speed_cmd[15:0], turn_cmd[15:0], step_us[15:0]
    input  logic [47:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // x_mm[31:0], y_mm[31:0], heading_deg[8:0], speed_echo[15:0], turn_echo[15:0], zero pad
    output logic [111:0] o_m_tdata
);
    import opi_pkg::*;

    localparam int NW = ((POS_FRAC_BITS > 23) ? POS_FRAC_BITS : 23) + 33;
    localparam int GW = POS_FRAC_BITS + 12;
    localparam int AW = GW + 24;
    localparam int CW = POS_FRAC_BITS + 14;
    localparam int SW = $clog2(NW + 1);
    localparam logic signed [48:0] POS_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] POS_MIN = -49'sh0_8000_0000_0000;

    t_state                r_state;
    t_phase                r_phase;
    logic [SW-1:0]         r_cnt;
    logic [15:0]           r_held_speed, r_held_turn, r_t;
    logic signed [47:0]    r_pos_x, r_pos_y;
    logic [31:0]           r_head, r_dth, r_half;
    logic signed [32:0]    r_p, r_wt;
    logic [NW-1:0]         r_num;
    logic [19:0]           r_rem;
    logic [GW-1:0]         r_dr_mag;
    logic [AW-1:0]         r_gm, r_gacc;
    logic signed [CW-1:0]  r_cx, r_cy;
    logic signed [33:0]    r_cz;
    logic                  r_m_valid;
    logic [111:0]          r_m_data;

    logic                  w_acc;
    logic [31:0]           w_pmag, w_wmag;
    logic [20:0]           w_den, w_rem2;
    logic                  w_ge;
    logic [NW-1:0]         w_q;
    logic [AW-1:0]         w_gnext;
    logic [AW:0]           w_rsum;
    logic signed [CW-1:0]  w_rr, w_xs, w_ys;
    logic [31:0]           w_mid;
    logic signed [48:0]    w_sx, w_sy;
    logic [40:0]           w_hprod;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] s);
        logic signed [47:0] res;
        if (s > POS_MAX)      res = POS_MAX[47:0];
        else if (s < POS_MIN) res = POS_MIN[47:0];
        else                  res = s[47:0];
        return res;
    endfunction

    function automatic logic [31:0] to_mm(input logic signed [47:0] p);
        logic signed [48:0] e, mag, sh, m;
        logic [31:0] res;
        e   = {p[47], p};
        mag = p[47] ? -e : e;
        sh  = mag >>> POS_FRAC_BITS;
        m   = p[47] ? -sh : sh;
        if (m > 49'sh0_0000_7FFF_FFFF)       res = 32'h7FFF_FFFF;
        else if (m < -49'sh0_0000_8000_0000) res = 32'h8000_0000;
        else                                 res = m[31:0];
        return res;
    endfunction

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    assign w_pmag = r_p[32] ? 32'(-r_p) : r_p[31:0];
    assign w_wmag = r_wt[32] ? 32'(-r_wt) : r_wt[31:0];

    assign w_den  = (r_phase == PH_DR) ? DEN_DR : DEN_ANG;
    assign w_rem2 = {r_rem, r_num[NW-1]};
    assign w_ge   = (w_rem2 >= w_den);
    assign w_q    = {r_num[NW-2:0], w_ge};

    assign w_gnext = INV_GAIN[r_cnt[4:0]] ? (r_gacc + r_gm) : r_gacc;
    assign w_rsum  = {1'b0, w_gnext} + (AW+1)'(24'h80_0000);
    assign w_rr    = r_p[32] ? -CW'(w_rsum >> 24) : CW'(w_rsum >> 24);
    assign w_mid   = r_head + r_half;

    assign w_xs = r_cx >>> r_cnt[4:0];
    assign w_ys = r_cy >>> r_cnt[4:0];

    assign w_sx = {r_pos_x[47], r_pos_x} + 49'(r_cx);
    assign w_sy = {r_pos_y[47], r_pos_y} + 49'(r_cy);

    assign w_hprod = {9'd0, r_head} * 41'd360;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_DR;
            r_cnt        <= '0;
            r_held_speed <= '0;
            r_held_turn  <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_head       <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_t <= i_s_tdata[47:32];
                        if (!i_s_tuser[0]) begin
                            r_pos_x <= '0;
                            r_pos_y <= '0;
                            r_head  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            if (i_s_tuser[1]) begin
                                r_held_speed <= i_s_tdata[15:0];
                                r_held_turn  <= i_s_tdata[31:16];
                            end
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_p     <= $signed(r_held_speed) * $signed({1'b0, r_t});
                    r_wt    <= $signed(r_held_turn) * $signed({1'b0, r_t});
                    r_phase <= PH_DR;
                    r_state <= S_LD;
                end
                S_LD: begin
                    case (r_phase)
                        PH_DR:   r_num <= (NW'(w_pmag) << POS_FRAC_BITS) + NW'(HALF_DR);
                        PH_DTH:  r_num <= (NW'(w_wmag) << 23) + NW'(HALF_ANG);
                        default: r_num <= (NW'(w_wmag) << 22) + NW'(HALF_ANG);
                    endcase
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= w_q;
                    r_rem <= w_ge ? 20'(w_rem2 - w_den) : w_rem2[19:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SW'(NW - 1)) begin
                        case (r_phase)
                            PH_DR: begin
                                r_dr_mag <= w_q[GW-1:0];
                                r_phase  <= PH_DTH;
                                r_state  <= S_LD;
                            end
                            PH_DTH: begin
                                r_dth   <= r_wt[32] ? -w_q[31:0] : w_q[31:0];
                                r_phase <= PH_HALF;
                                r_state <= S_LD;
                            end
                            default: begin
                                r_half  <= r_wt[32] ? -w_q[31:0] : w_q[31:0];
                                r_gm    <= AW'(r_dr_mag);
                                r_gacc  <= '0;
                                r_cnt   <= '0;
                                r_state <= S_GAIN;
                            end
                        endcase
                    end
                end
                S_GAIN: begin
                    r_gacc <= w_gnext;
                    r_gm   <= r_gm << 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == SW'(GAIN_STEPS - 1)) begin
                        if (w_mid[31] ^ w_mid[30]) begin
                            r_cx <= -w_rr;
                            r_cz <= 34'($signed(w_mid ^ 32'h8000_0000));
                        end else begin
                            r_cx <= w_rr;
                            r_cz <= 34'($signed(w_mid));
                        end
                        r_cy    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - $signed({2'b00, ATAN_TAB[r_cnt[4:0]]});
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + $signed({2'b00, ATAN_TAB[r_cnt[4:0]]});
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_pos_x <= sat48(w_sx);
                    r_pos_y <= sat48(w_sy);
                    r_head  <= r_head + r_dth;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {7'd0, r_held_turn, r_held_speed, w_hprod[40:32],
                                      to_mm(r_pos_y), to_mm(r_pos_x)};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/opi_checker.sv =====
// Port-level checks of the odometry integrator and their binding to the top level.
`include "assert_macros.svh"

module opi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [1:0]   i_s_tuser,
    input logic [47:0]  i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [111:0] o_m_tdata
);

    `CHK_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `CHK_NOW(a_heading_range, o_m_tvalid, o_m_tdata[72:64] <= 9'd359)
    `CHK_NEXT(a_busy_after_beat, i_s_tvalid && o_s_tready, !o_s_tready)
    `CHK_NEXT_RST(a_reset_clears, !i_rst_n, !o_m_tvalid && o_s_tready)

endmodule

bind odometry_pose_integrator_core opi_checker u_opi_checker (.*);

// ===== test/tb.sv =====
// Self-checking stream testbench for the odometry pose integrator core.
module tb;
    localparam int STEPS = 24;
    localparam int FRAC = 16;
    localparam longint PMAX = 64'sd140737488355327;
    localparam longint PMIN = -PMAX - 1;
    localparam int LIMIT = 4000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [1:0]   i_s_tuser = '0;
    logic [47:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [111:0] o_m_tdata;

    odometry_pose_integrator_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [49:0]  tick_q[$];
    logic [111:0] pose_q[$];
    logic [15:0]  held_speed = '0, held_turn = '0;
    longint       pos_x = 0, pos_y = 0;
    logic [31:0]  heading = '0;
    int           errors = 0;
    int           cycles = 0;
    bit           calm = 0;
    bit           hold = 0;

    function automatic longint rdiv(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] mm_of(longint p);
        longint mm;
        mm = (p >= 0) ? (p >>> FRAC) : -((-p) >>> FRAC);
        if (mm > 64'sd2147483647) mm = 64'sd2147483647;
        if (mm < -64'sd2147483648) mm = -64'sd2147483648;
        return mm[31:0];
    endfunction

    function automatic logic [111:0] integrate_tick(logic [49:0] d);
        longint v, w, t, dr, dth, half, x, y, z, xs, ys;
        logic [31:0] mid;
        logic [63:0] hd;
        if (!d[0]) begin
            pos_x = 0; pos_y = 0; heading = '0;
        end else begin
            if (d[1]) begin
                held_speed = d[17:2];
                held_turn = d[33:18];
            end
            v = longint'($signed(held_speed));
            w = longint'($signed(held_turn));
            t = longint'(d[49:34]);
            dr = rdiv(v * t * (64'sd1 << FRAC), 1000000);
            dth = rdiv(w * t * 8388608, 703125);
            half = rdiv(w * t * 4194304, 703125);
            mid = heading + half[31:0];
            x = rdiv(dr * 10188014, 16777216);
            y = 0;
            if (mid >= 32'h4000_0000 && mid < 32'hC000_0000) begin
                x = -x;
                mid = mid - 32'h8000_0000;
            end
            z = longint'($signed(mid));
            for (int i = 0; i < STEPS && i < 32; i++) begin
                xs = shr(x, i);
                ys = shr(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(opi_pkg::ATAN_TAB[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(opi_pkg::ATAN_TAB[i]);
                end
            end
            pos_x = pos_x + x;
            pos_y = pos_y + y;
            if (pos_x > PMAX) pos_x = PMAX;
            if (pos_x < PMIN) pos_x = PMIN;
            if (pos_y > PMAX) pos_y = PMAX;
            if (pos_y < PMIN) pos_y = PMIN;
            heading = heading + dth[31:0];
        end
        hd = (64'(heading) * 360) >> 32;
        return {7'd0, held_turn, held_speed, hd[8:0], mm_of(pos_y), mm_of(pos_x)};
    endfunction

    function automatic logic [49:0] make_tick(bit sub, bit cmd, logic [15:0] sp,
                                              logic [15:0] tr, logic [15:0] st);
        return {st, tr, sp, cmd, sub};
    endfunction

    function automatic logic [15:0] rand_cmd();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 40)) - 16'd20;
            3: return 16'($urandom_range(0, 2000)) - 16'd1000;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pose_q.push_back(integrate_tick({i_s_tdata, i_s_tuser}));
                void'(tick_q.pop_front());
            end
            if (tick_q.size() > 0 && !hold && (calm || $urandom_range(0, 99) >= 14)) begin
                i_s_tvalid <= 1'b1;
                if (!(i_s_tvalid && !o_s_tready)) begin
                    i_s_tdata <= tick_q[0][49:2];
                    i_s_tuser <= tick_q[0][1:0];
                end
            end else if (!(i_s_tvalid && !o_s_tready)) begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pose_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected beat %h", o_m_tdata);
                end else begin
                    logic [111:0] e;
                    e = pose_q.pop_front();
                    if (e != o_m_tdata) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch x %0d/%0d y %0d/%0d hd %0d/%0d sp %h/%h tr %h/%h",
                                $signed(e[31:0]), $signed(o_m_tdata[31:0]),
                                $signed(e[63:32]), $signed(o_m_tdata[63:32]),
                                e[72:64], o_m_tdata[72:64], e[88:73], o_m_tdata[88:73],
                                e[104:89], o_m_tdata[104:89]);
                    end
                end
            end
            i_m_tready <= calm || $urandom_range(0, 99) >= 14;
        end
    end

    initial begin
        logic [15:0] sp, tr;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tick_q.push_back(make_tick(1, 0, 16'd0, 16'd0, 16'd1000));
        tick_q.push_back(make_tick(1, 1, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        tick_q.push_back(make_tick(1, 0, 16'h0, 16'h0, 16'hFFFF));
        tick_q.push_back(make_tick(1, 1, 16'h8000, 16'h8000, 16'hFFFF));
        tick_q.push_back(make_tick(1, 1, 16'd500, 16'hFFA6, 16'd0));
        tick_q.push_back(make_tick(1, 0, 16'd0, 16'd0, 16'd20000));
        tick_q.push_back(make_tick(0, 1, 16'h1234, 16'h5678, 16'd10000));
        tick_q.push_back(make_tick(1, 1, 16'd1000, 16'd90, 16'd50000));
        tick_q.push_back(make_tick(1, 1, 16'd1000, 16'hFF4C, 16'd50000));
        tick_q.push_back(make_tick(1, 1, 16'h7FFF, 16'd0, 16'hFFFF));
        for (int i = 0; i < 12; i++)
            tick_q.push_back(make_tick(1, 0, 16'd0, 16'd0, 16'hFFFF));
        tick_q.push_back(make_tick(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        wait (tick_q.size() == 0);
        hold = 1;
        wait (pose_q.size() == 0);
        hold = 0;
        for (int i = 0; i < 1800; i++) begin
            if (i == 300) calm = 1;
            if (i == 500) calm = 0;
            sp = rand_cmd();
            tr = rand_cmd();
            tick_q.push_back(make_tick($urandom_range(0, 49) != 0, $urandom_range(0, 3) == 0,
                sp, tr, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom)));
            if (tick_q.size() > 8) wait (tick_q.size() <= 8);
        end
        wait (tick_q.size() == 0);
        wait (pose_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/opi_pkg.sv
hdl/odometry_pose_integrator_core.sv
hdl/opi_checker.sv
test/tb.sv
